@@ sv/utf8_stream_validator_assert.svh @@
// Assertion macros used by the validator top level; clk and rst_n come from the using scope.
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define U8V_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define U8V_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/u8v_pkg.sv @@
// Shared types and constants of the UTF-8 stream validator.
package u8v_pkg;

  // Byte masks and bounds used by the classifier
  localparam logic [7:0] MASK_C0   = 8'hc0;
  localparam logic [7:0] MASK_E0   = 8'he0;
  localparam logic [7:0] MASK_F0   = 8'hf0;
  localparam logic [7:0] MASK_F8   = 8'hf8;
  localparam logic [7:0] MASK_FE   = 8'hfe;
  localparam logic [7:0] PAT_CONT  = 8'h80;
  localparam logic [7:0] PAT_LEAD2 = 8'hc0;
  localparam logic [7:0] PAT_LEAD3 = 8'he0;
  localparam logic [7:0] PAT_LEAD4 = 8'hf0;
  localparam logic [7:0] BYTE_E0   = 8'he0;
  localparam logic [7:0] BYTE_ED   = 8'hed;
  localparam logic [7:0] BYTE_F0   = 8'hf0;
  localparam logic [7:0] BYTE_F4   = 8'hf4;
  localparam logic [7:0] LIM_8F    = 8'h8f;
  localparam logic [7:0] LIM_90    = 8'h90;
  localparam logic [7:0] LIM_9F    = 8'h9f;
  localparam logic [7:0] LIM_A0    = 8'ha0;

  // First-continuation range rules
  localparam logic [2:0] RULE_NONE  = 3'd0;
  localparam logic [2:0] RULE_A0_BF = 3'd1;
  localparam logic [2:0] RULE_80_9F = 3'd2;
  localparam logic [2:0] RULE_90_BF = 3'd3;
  localparam logic [2:0] RULE_80_8F = 3'd4;

  // Queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Classified byte as it travels from front to back
  typedef struct packed {
    logic       cont;       // byte is 10xxxxxx
    logic [4:1] allow;      // byte meets each first-continuation rule
    logic [1:0] lead_pend;  // continuations owed if taken as a lead
    logic [2:0] lead_rule;  // rule for the next byte if taken as a lead
    logic       lead_bad;   // byte is no legal lead
    logic       last;       // final byte of the message
  } tok_t;

  // Queue status toward front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ sv/u8v_front.sv @@
// Front end: accepts input bytes and classifies them into tokens.
module u8v_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  input  u8v_pkg::q_stat_t q_stat,
  output logic            push,
  output u8v_pkg::tok_t   tok
);
  import u8v_pkg::*;

  logic [7:0] b;

  assign b        = in_data_byte;
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Classify the byte for both continuation and lead use
  always_comb begin
    tok           = '0;
    tok.last      = in_last_byte;
    tok.cont      = (b & MASK_C0) == PAT_CONT;
    tok.allow[1]  = (b >= LIM_A0) && tok.cont;
    tok.allow[2]  = (b <= LIM_9F) && tok.cont;
    tok.allow[3]  = (b >= LIM_90) && tok.cont;
    tok.allow[4]  = (b <= LIM_8F) && tok.cont;
    if (!b[7]) begin
      tok.lead_pend = 2'd0;
    end else if ((b & MASK_E0) == PAT_LEAD2) begin
      // drop overlong C0 and C1
      tok.lead_bad  = (b & MASK_FE) == PAT_LEAD2;
      tok.lead_pend = tok.lead_bad ? 2'd0 : 2'd1;
    end else if ((b & MASK_F0) == PAT_LEAD3) begin
      tok.lead_pend = 2'd2;
      if (b == BYTE_E0) begin
        tok.lead_rule = RULE_A0_BF;
      end else if (b == BYTE_ED) begin
        tok.lead_rule = RULE_80_9F;
      end
    end else if (((b & MASK_F8) == PAT_LEAD4) && (b <= BYTE_F4)) begin
      tok.lead_pend = 2'd3;
      if (b == BYTE_F0) begin
        tok.lead_rule = RULE_90_BF;
      end else if (b == BYTE_F4) begin
        tok.lead_rule = RULE_80_8F;
      end
    end else begin
      // stray continuation or lead above F4
      tok.lead_bad = 1'b1;
    end
  end

endmodule

@@ sv/u8v_queue.sv @@
// Two-entry token queue between classifier and decoder.
module u8v_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8v_pkg::tok_t    push_tok,
  input  logic             pop,
  output u8v_pkg::tok_t    head_tok,
  output u8v_pkg::q_stat_t q_stat
);
  import u8v_pkg::*;

  tok_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign head_tok     = slot_r[rd_ptr_r];
  assign q_stat.empty = cnt_r == '0;
  assign q_stat.full  = cnt_r == Q_CNT_W'(Q_DEPTH);

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

@@ sv/u8v_back.sv @@
// Back end: sequence state, sticky error and the result register.
module u8v_back (
  input  logic             clk,
  input  logic             rst_n,
  input  u8v_pkg::q_stat_t q_stat,
  input  u8v_pkg::tok_t    head_tok,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_message_valid
);
  import u8v_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic [2:0] rule_r, rule_nxt;
  logic       err_r, err_nxt;
  logic       ov_r, ov_nxt;
  logic       mv_r, mv_nxt;
  logic       rule_ok;
  logic [1:0] pend_upd;
  logic       err_upd;

  assign out_valid         = ov_r;
  assign out_message_valid = mv_r;

  // Take a token unless it carries a result that cannot be placed
  assign pop = !q_stat.empty && (!head_tok.last || !ov_r || !out_stall);

  // Check the first continuation against the pending rule
  always_comb begin
    unique case (rule_r)
      RULE_A0_BF: rule_ok = head_tok.allow[1];
      RULE_80_9F: rule_ok = head_tok.allow[2];
      RULE_90_BF: rule_ok = head_tok.allow[3];
      RULE_80_8F: rule_ok = head_tok.allow[4];
      default:    rule_ok = 1'b1;
    endcase
  end

  // Decode one token
  always_comb begin
    pend_upd = pend_r;
    rule_nxt = rule_r;
    err_upd  = err_r;
    if (pend_r != 2'd0) begin
      rule_nxt = RULE_NONE;
      if (!head_tok.cont || !rule_ok) begin
        err_upd  = 1'b1;
        pend_upd = 2'd0;
      end else begin
        pend_upd = pend_r - 2'd1;
      end
    end else begin
      pend_upd = head_tok.lead_pend;
      rule_nxt = head_tok.lead_rule;
      err_upd  = err_r | head_tok.lead_bad;
    end
    pend_nxt = pend_upd;
    err_nxt  = err_upd;
    ov_nxt   = ov_r && out_stall;
    mv_nxt   = mv_r;
    if (!pop) begin
      pend_nxt = pend_r;
      rule_nxt = rule_r;
      err_nxt  = err_r;
    end else if (head_tok.last) begin
      // give the result and clear the message state
      ov_nxt   = 1'b1;
      mv_nxt   = !err_upd && (pend_upd == 2'd0);
      pend_nxt = 2'd0;
      rule_nxt = RULE_NONE;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      rule_r <= RULE_NONE;
      err_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      rule_r <= rule_nxt;
      err_r  <= err_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    mv_r <= mv_nxt;
  end

endmodule

@@ sv/utf8_stream_validator.sv @@
// Top level of the strict UTF-8 stream validator.
// Usage:
//   Input channel in_: one message byte per request on in_data_byte, with
//   in_last_byte high on the message's final byte. A request is taken at a
//   rising edge with in_valid high and in_stall low.
//   Result channel out_: one request per message, out_message_valid high when
//   the whole message was well-formed UTF-8; taken when out_valid is high and
//   out_stall is low.
// Throughput: one byte per cycle while in_stall is low; the per-byte state
//   update in the decoder is the registered loop that sets this rate.
// Result path: the final byte is written into the two-entry token queue, then
//   moves through the decoder into the result register, which drives
//   out_valid.
// Stall: the result register holds while out_stall is high; bytes keep
//   flowing until a final byte meets an occupied result register, after
//   which the queue fills and in_stall rises.
// Reset: synchronous rst_n clears the queue, the sequence state, the sticky
//   error and out_valid; the block accepts bytes the cycle after reset.
module utf8_stream_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_message_valid
);
  import u8v_pkg::*;

  tok_t    push_tok;
  tok_t    head_tok;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  // Classify incoming bytes
  u8v_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_stat       (q_stat),
    .push         (push),
    .tok          (push_tok)
  );

  // Buffer tokens between the two halves
  u8v_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .q_stat   (q_stat)
  );

  // Decode tokens and produce results
  u8v_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .head_tok          (head_tok),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_message_valid (out_message_valid)
  );

`include "utf8_stream_validator_assert.svh"

  `U8V_ASSERT_IMP(a_pop_not_empty, pop, !q_stat.empty, "pop from empty queue")
  `U8V_ASSERT_NXT(a_push_fills, push, !q_stat.empty, "queue empty after push")
  `U8V_ASSERT_IMP(a_result_room, pop && head_tok.last, !out_valid || !out_stall, "result overwritten")

endmodule
